@@ sv/ehash_pkg.sv @@
// Shared types, constants and the hash step function of the string hash block.
package ehash_pkg;

  localparam int unsigned HASH_W   = 28;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BUCKET_W = 16;
  localparam int unsigned ADDR_W   = 1;
  localparam int unsigned DATA_W   = 32;

  localparam int unsigned FIFO_DEPTH_DEFAULT = 4;

  localparam logic [BUCKET_W-1:0] BUCKET_COUNT_RESET = 16'd1024;
  localparam logic [ADDR_W-1:0]   REG_BUCKET_COUNT   = 1'b0;

  typedef logic [HASH_W-1:0] hash_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // shift in one byte, fold the top nibble in at bit 4 and clear it
  function automatic hash_t hash_step(input hash_t h, input logic [BYTE_W-1:0] b);
    logic [HASH_W+3:0] t;
    logic [3:0]        top;
    begin
      t   = {h, 4'b0000} + {{(HASH_W-4){1'b0}}, b};
      top = t[HASH_W+3:HASH_W];
      return t[HASH_W-1:0] ^ {{(HASH_W-8){1'b0}}, top, 4'b0000};
    end
  endfunction

endpackage

@@ sv/ehash_front.sv @@
// Front end: takes input bytes, keeps the running hash, queues the finished hash.
module ehash_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ehash_pkg::BYTE_W-1:0]      data_byte_i,
  input  logic                              has_byte_i,
  input  logic                              last_byte_i,
  input  ehash_pkg::qstat_t                 qstat_i,
  output logic                              push_o,
  output ehash_pkg::hash_t                  push_hash_o
);

  ehash_pkg::hash_t hash_q, hash_d, upd;
  logic             accept;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign upd        = has_byte_i ? ehash_pkg::hash_step(hash_q, data_byte_i) : hash_q;

  assign push_o      = accept && last_byte_i;
  assign push_hash_o = upd;

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      hash_d = last_byte_i ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

@@ sv/ehash_fifo.sv @@
// Short queue of finished hashes between the front end and the divider.
module ehash_fifo #(
  parameter int unsigned Depth = ehash_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ehash_pkg::hash_t  push_hash_i,
  input  logic              pop_i,
  output ehash_pkg::hash_t  pop_hash_o,
  output ehash_pkg::qstat_t qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ehash_pkg::hash_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CntW'(Depth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign pop_hash_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_hash_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full)
    else $error("hash pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty)
    else $error("hash popped from an empty queue");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

@@ sv/ehash_back.sv @@
// Back end: bit-serial modulo of the queued hash and the output register.
module ehash_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ehash_pkg::qstat_t                  qstat_i,
  input  ehash_pkg::hash_t                   pop_hash_i,
  output logic                               pop_o,
  input  logic [ehash_pkg::BUCKET_W-1:0]     bucket_count_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ehash_pkg::BUCKET_W-1:0]     bucket_index_o,
  output ehash_pkg::hash_t                   hash_value_o
);

  localparam int unsigned HW   = ehash_pkg::HASH_W;
  localparam int unsigned BW   = ehash_pkg::BUCKET_W;
  localparam int unsigned CntW = $clog2(HW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  ehash_pkg::hash_t hash_q, hash_d, dvd_q, dvd_d;
  logic [BW-1:0]    div_q, div_d, rem_q, rem_d;
  logic [BW:0]      trial, diff;
  logic             out_valid_q, out_valid_d, out_free, load_out;
  logic [BW-1:0]    bucket_q, bucket_d;
  ehash_pkg::hash_t hval_q, hval_d;

  assign trial    = {rem_q, dvd_q[HW-1]};
  assign diff     = trial - {1'b0, div_q};
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !qstat_i.empty;
  assign load_out = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hash_d  = hash_q;
    dvd_d   = dvd_q;
    div_d   = div_q;
    rem_d   = rem_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          hash_d  = pop_hash_i;
          dvd_d   = pop_hash_i;
          div_d   = bucket_count_i;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // one quotient bit per cycle, restoring form
        rem_d = diff[BW] ? trial[BW-1:0] : diff[BW-1:0];
        dvd_d = {dvd_q[HW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(HW - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    bucket_d    = bucket_q;
    hval_d      = hval_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      bucket_d    = (div_q == '0) ? '0 : rem_q;
      hval_d      = hash_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q   <= hash_d;
    dvd_q    <= dvd_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
    bucket_q <= bucket_d;
    hval_q   <= hval_d;
  end

  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = bucket_q;
  assign hash_value_o   = hval_q;

endmodule

@@ sv/elf_string_hash_bucket.sv @@
// Top level of the ELF/PJW string hash with bucket selection.
// The block hashes a string one byte per input word and, on the word marked
// last, returns the 28-bit ELF/PJW hash and that hash modulo bucket_count.
// Bytes are taken one per cycle, with no gap between words or strings, as
// long as the result queue has room. Each string's end hands the hash to a
// bit-serial divider that works one string at a time (one load, 28 remainder
// steps, one hand-over to the output register) and takes the next hash only
// after the hand-over; a queue of FifoDepth hashes absorbs back-to-back short
// strings. A word with has_byte low and last_byte low is taken and dropped;
// a lone last word without a byte gives hash 0 and bucket 0. A bucket_count
// of zero yields bucket 0. bucket_count sits at byte address 0 of the APB
// port and resets to 1024; write it only while no string is in flight.
module elf_string_hash_bucket #(
  parameter int unsigned FifoDepth = ehash_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ehash_pkg::ADDR_W-1:0]       paddr,
  input  logic [ehash_pkg::DATA_W-1:0]       pwdata,
  output logic [ehash_pkg::DATA_W-1:0]       prdata,
  output logic                               pready,
  // input byte stream
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ehash_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                               has_byte_i,
  input  logic                               last_byte_i,
  // result stream
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ehash_pkg::BUCKET_W-1:0]     bucket_index_o,
  output logic [ehash_pkg::HASH_W-1:0]       hash_value_o
);

  logic [ehash_pkg::BUCKET_W-1:0] bucket_count_q, bucket_count_d;
  ehash_pkg::qstat_t              qstat;
  ehash_pkg::hash_t               push_hash, pop_hash;
  logic                           push, pop;

  // Register file: one writable register, always ready.
  assign pready = 1'b1;

  always_comb begin
    bucket_count_d = bucket_count_q;
    if (psel && penable && pwrite && pready && (paddr == ehash_pkg::REG_BUCKET_COUNT)) begin
      bucket_count_d = pwdata[ehash_pkg::BUCKET_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ehash_pkg::REG_BUCKET_COUNT) begin
      prdata = {{(ehash_pkg::DATA_W-ehash_pkg::BUCKET_W){1'b0}}, bucket_count_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= ehash_pkg::BUCKET_COUNT_RESET;
    end else begin
      bucket_count_q <= bucket_count_d;
    end
  end

  // Front end: fold each byte into the running hash, push on the last word.
  ehash_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .last_byte_i (last_byte_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_hash_o (push_hash)
  );

  // Queue: hold finished hashes while the divider works.
  ehash_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_hash_i (push_hash),
    .pop_i       (pop),
    .pop_hash_o  (pop_hash),
    .qstat_o     (qstat)
  );

  // Back end: reduce modulo bucket_count and present the result word.
  ehash_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .qstat_i        (qstat),
    .pop_hash_i     (pop_hash),
    .pop_o          (pop),
    .bucket_count_i (bucket_count_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bucket_index_o (bucket_index_o),
    .hash_value_o   (hash_value_o)
  );

endmodule
